// ===== sv/kcl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcl_pkg
// Shared types, codes and constants of the keypad code lock controller.
// ----------------------------------------------------------------------------
package kcl_pkg;

  // Number of digits in a lock code (1 to 8).
  localparam int CODE_LENGTH     = 4;
  localparam int MAX_CODE_LENGTH = 8;

  // Cursor runs 0..CODE_LENGTH, the digit index 0..CODE_LENGTH-1.
  localparam int CUR_W = $clog2(CODE_LENGTH + 1);
  localparam int IDX_W = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;

  localparam int KEY_W   = 8;
  localparam int DIGIT_W = 4;
  localparam int FILL_W  = 8;

  // Default code 1234, padded with leading zeros up to the longest code.
  localparam logic [DIGIT_W-1:0] DEFAULT_DIGITS [MAX_CODE_LENGTH] =
    '{4'd0, 4'd0, 4'd0, 4'd0, 4'd1, 4'd2, 4'd3, 4'd4};

  // ASCII key codes.
  localparam logic [KEY_W-1:0] KEY_PLUS  = 8'h2B;
  localparam logic [KEY_W-1:0] KEY_DOT   = 8'h2E;
  localparam logic [KEY_W-1:0] KEY_EQ    = 8'h3D;
  localparam logic [KEY_W-1:0] KEY_SLASH = 8'h2F;
  localparam logic [KEY_W-1:0] KEY_0     = 8'h30;
  localparam logic [KEY_W-1:0] KEY_1     = 8'h31;
  localparam logic [KEY_W-1:0] KEY_2     = 8'h32;
  localparam logic [KEY_W-1:0] KEY_3     = 8'h33;
  localparam logic [KEY_W-1:0] KEY_9     = 8'h39;

  typedef enum logic [1:0] {
    MODE_LOGIN   = 2'd0,
    MODE_MENU    = 2'd1,
    MODE_NEW     = 2'd2,
    MODE_REENTER = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ACT_NONE  = 3'd0,
    ACT_DIGIT = 3'd1,
    ACT_LEFT  = 3'd2,
    ACT_RIGHT = 3'd3,
    ACT_ERASE = 3'd4,
    ACT_MSG   = 3'd5
  } act_t;

  typedef enum logic [3:0] {
    MSG_NONE      = 4'd0,
    MSG_PROMPT    = 4'd1,
    MSG_SHORT     = 4'd2,
    MSG_CORRECT   = 4'd3,
    MSG_INCORRECT = 4'd4,
    MSG_MENU      = 4'd5,
    MSG_NEW       = 4'd6,
    MSG_REENTER   = 4'd7,
    MSG_CHANGED   = 4'd8,
    MSG_MISMATCH  = 4'd9
  } msg_t;

  // One result of a key request.
  typedef struct packed {
    mode_t               mode_now;
    logic                alarm_pulse;
    logic                door_open;
    msg_t                message;
    logic [DIGIT_W-1:0]  display_digit;
    act_t                display_action;
  } result_t;

  localparam int RESULT_W = $bits(result_t);
  localparam int OUT_DATA_W = ((RESULT_W + 7) / 8) * 8;

  // Handshake state of a register stage.
  typedef struct packed {
    logic valid;
    logic ready;
  } stage_ctl_t;

endpackage

// ===== sv/keypad_code_lock_controller_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_code_lock_controller_unit
// Door-lock controller driven by ASCII keypad codes: login, menu, new code
// and re-entry modes, one display/door result per key.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Payload                                       Handshake
//  s_axis    in   tdata[7:0] key_code                           tvalid/tready
//  m_axis    out  tdata[15:0] action, digit, message, door,     tvalid/tready
//                 alarm, mode (see port comment)
//
//  A key request accepted into the input register moves to the output
//  register when it has room: the input register feeds the lock core,
//  whose combinational update loads the output register.
//  One request is accepted every cycle while results drain; the core's
//  update of the mode and cursor registers with each key sets that rate.
//  A stalled m_axis holds the output register, then the input register,
//  then drops s_axis_tready.
//  Synchronous rst restores login mode, empty entry, closed door and the
//  default code; pending requests and results are dropped.
//
module keypad_code_lock_controller_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,  // [7:0] key_code
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [2:0] display_action, [6:3] display_digit, [10:7] message,
  // [11] door_open, [12] alarm_pulse, [14:13] mode_now, [15] zero
  output logic [kcl_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  kcl_pkg::stage_ctl_t            key_ctl, res_ctl;
  logic [kcl_pkg::KEY_W-1:0]      key;
  logic                           advance;
  kcl_pkg::result_t               core_result, held_result;

  // Advance a held key into the core when the output register has room.
  assign advance = key_ctl.valid && res_ctl.ready;

  kcl_key_stage u_key_stage (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_key   (s_axis_tdata),
    .advance  (advance),
    .ctl      (key_ctl),
    .key      (key)
  );

  kcl_lock_core u_lock_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .key    (key),
    .result (core_result)
  );

  kcl_result_stage u_result_stage (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .result_in (core_result),
    .out_ready (m_axis_tready),
    .ctl       (res_ctl),
    .result    (held_result)
  );

  assign s_axis_tready = key_ctl.ready;
  assign m_axis_tvalid = res_ctl.valid;

  // Pack fields from the lowest bit up, pad the top with zeros.
  assign m_axis_tdata = kcl_pkg::OUT_DATA_W'(held_result);

endmodule

// ===== sv/kcl_key_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcl_key_stage
// Input register: holds one key request until the core consumes it.
// ----------------------------------------------------------------------------
module kcl_key_stage (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic [kcl_pkg::KEY_W-1:0] in_key,
  input  logic                      advance,
  output kcl_pkg::stage_ctl_t       ctl,
  output logic [kcl_pkg::KEY_W-1:0] key
);

  logic valid;

  // Take a new key when empty or when the held one leaves this cycle.
  assign ctl.ready = !valid || advance;
  assign ctl.valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ready && in_valid) begin
      key <= in_key;
    end
  end

endmodule

// ===== sv/kcl_lock_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcl_lock_core
// Lock state (mode, cursor, fill count, digit stores, door) and the
// single-pass update that turns one key into one result.
// ----------------------------------------------------------------------------
module kcl_lock_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      fire,
  input  logic [kcl_pkg::KEY_W-1:0] key,
  output kcl_pkg::result_t          result
);

  localparam logic [kcl_pkg::CUR_W-1:0]  CUR_FULL  = kcl_pkg::CUR_W'(kcl_pkg::CODE_LENGTH);
  localparam logic [kcl_pkg::FILL_W-1:0] FILL_FULL = kcl_pkg::FILL_W'(kcl_pkg::CODE_LENGTH);

  kcl_pkg::mode_t mode, mode_next;
  logic [kcl_pkg::CUR_W-1:0]   cursor, cursor_next;
  logic [kcl_pkg::FILL_W-1:0]  fill_count, fill_count_next;
  logic                        door_state, door_state_next;
  logic [kcl_pkg::DIGIT_W-1:0] entry_digits       [kcl_pkg::CODE_LENGTH];
  logic [kcl_pkg::DIGIT_W-1:0] first_entry_digits [kcl_pkg::CODE_LENGTH];
  logic [kcl_pkg::DIGIT_W-1:0] stored_code        [kcl_pkg::CODE_LENGTH];

  logic is_entry, is_digit, short_fill, login_ok, reenter_ok;
  logic do_submit, do_left, do_right, do_erase, do_digit;
  logic save_first, save_code;
  logic [kcl_pkg::DIGIT_W-1:0] key_digit;
  logic [kcl_pkg::IDX_W-1:0]   wr_idx;

  // Decode the key against the current position.
  always_comb begin
    is_entry   = (mode != kcl_pkg::MODE_MENU);
    is_digit   = (key >= kcl_pkg::KEY_0) && (key <= kcl_pkg::KEY_9);
    key_digit  = kcl_pkg::DIGIT_W'(key - kcl_pkg::KEY_0);
    wr_idx     = cursor[kcl_pkg::IDX_W-1:0];
    short_fill = (fill_count < FILL_FULL);
    do_submit  = is_entry && (key == kcl_pkg::KEY_PLUS) && (cursor == CUR_FULL);
    do_left    = is_entry && (key == kcl_pkg::KEY_DOT) && (cursor != '0);
    do_right   = is_entry && (key == kcl_pkg::KEY_EQ) && (cursor < CUR_FULL);
    do_erase   = is_entry && (key == kcl_pkg::KEY_SLASH) && (cursor != '0)
                 && (cursor <= CUR_FULL);
    do_digit   = is_entry && is_digit && (cursor < CUR_FULL);
    login_ok   = 1'b1;
    reenter_ok = 1'b1;
    for (int i = 0; i < kcl_pkg::CODE_LENGTH; i++) begin
      if (entry_digits[i] != stored_code[i]) begin
        login_ok = 1'b0;
      end
      if (first_entry_digits[i] != entry_digits[i]) begin
        reenter_ok = 1'b0;
      end
    end
  end

  // Mode transitions.
  always_comb begin
    mode_next = mode;
    unique case (mode)
      kcl_pkg::MODE_MENU: begin
        if (key == kcl_pkg::KEY_3) begin
          mode_next = kcl_pkg::MODE_NEW;
        end
      end
      kcl_pkg::MODE_LOGIN: begin
        if (do_submit && !short_fill && login_ok) begin
          mode_next = kcl_pkg::MODE_MENU;
        end
      end
      kcl_pkg::MODE_NEW: begin
        if (do_submit && !short_fill) begin
          mode_next = kcl_pkg::MODE_REENTER;
        end
      end
      kcl_pkg::MODE_REENTER: begin
        if (do_submit && !short_fill) begin
          mode_next = reenter_ok ? kcl_pkg::MODE_LOGIN : kcl_pkg::MODE_MENU;
        end
      end
      default: mode_next = mode;
    endcase
  end

  // Result fields and data path updates.
  always_comb begin
    result.display_action = kcl_pkg::ACT_NONE;
    result.display_digit  = '0;
    result.message        = kcl_pkg::MSG_NONE;
    result.alarm_pulse    = 1'b0;
    cursor_next           = cursor;
    fill_count_next       = fill_count;
    door_state_next       = door_state;
    save_first            = 1'b0;
    save_code             = 1'b0;
    if (!is_entry) begin
      if (key == kcl_pkg::KEY_1) begin
        door_state_next = 1'b1;
      end else if (key == kcl_pkg::KEY_2) begin
        door_state_next = 1'b0;
      end else if (key == kcl_pkg::KEY_3) begin
        cursor_next           = '0;
        fill_count_next       = '0;
        result.display_action = kcl_pkg::ACT_MSG;
        result.message        = kcl_pkg::MSG_NEW;
      end
    end else if (do_submit) begin
      cursor_next           = '0;
      fill_count_next       = '0;
      result.display_action = kcl_pkg::ACT_MSG;
      if (short_fill) begin
        result.message = kcl_pkg::MSG_SHORT;
      end else begin
        unique case (mode)
          kcl_pkg::MODE_LOGIN: begin
            result.message     = login_ok ? kcl_pkg::MSG_CORRECT : kcl_pkg::MSG_INCORRECT;
            result.alarm_pulse = !login_ok;
          end
          kcl_pkg::MODE_NEW: begin
            result.message = kcl_pkg::MSG_REENTER;
            save_first     = 1'b1;
          end
          kcl_pkg::MODE_REENTER: begin
            result.message     = reenter_ok ? kcl_pkg::MSG_CHANGED : kcl_pkg::MSG_MISMATCH;
            result.alarm_pulse = !reenter_ok;
            save_code          = reenter_ok;
          end
          default: result.message = kcl_pkg::MSG_NONE;
        endcase
      end
    end else if (do_left) begin
      cursor_next           = cursor - 1'b1;
      result.display_action = kcl_pkg::ACT_LEFT;
    end else if (do_right) begin
      cursor_next           = cursor + 1'b1;
      result.display_action = kcl_pkg::ACT_RIGHT;
    end else if (do_erase) begin
      cursor_next           = cursor - 1'b1;
      fill_count_next       = fill_count - 1'b1;
      result.display_action = kcl_pkg::ACT_ERASE;
    end else if (do_digit) begin
      cursor_next           = cursor + 1'b1;
      fill_count_next       = fill_count + 1'b1;
      result.display_action = kcl_pkg::ACT_DIGIT;
      result.display_digit  = key_digit;
    end
    result.door_open = door_state_next;
    result.mode_now  = mode_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= kcl_pkg::MODE_LOGIN;
      cursor     <= '0;
      fill_count <= '0;
      door_state <= 1'b0;
    end else if (fire) begin
      mode       <= mode_next;
      cursor     <= cursor_next;
      fill_count <= fill_count_next;
      door_state <= door_state_next;
    end
  end

  // Entry and first-entry digits start undefined.
  always_ff @(posedge clk) begin
    for (int i = 0; i < kcl_pkg::CODE_LENGTH; i++) begin
      if (fire && do_digit && (wr_idx == kcl_pkg::IDX_W'(i))) begin
        entry_digits[i] <= key_digit;
      end
      if (fire && save_first) begin
        first_entry_digits[i] <= entry_digits[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < kcl_pkg::CODE_LENGTH; i++) begin
      if (rst) begin
        stored_code[i] <=
          kcl_pkg::DEFAULT_DIGITS[kcl_pkg::MAX_CODE_LENGTH - kcl_pkg::CODE_LENGTH + i];
      end else if (fire && save_code) begin
        stored_code[i] <= first_entry_digits[i];
      end
    end
  end

endmodule

// ===== sv/kcl_result_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcl_result_stage
// Output register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module kcl_result_stage (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    load,
  input  kcl_pkg::result_t        result_in,
  input  logic                    out_ready,
  output kcl_pkg::stage_ctl_t     ctl,
  output kcl_pkg::result_t        result
);

  logic valid;

  // Room for a new result when empty or when the held one is taken now.
  assign ctl.ready = !valid || out_ready;
  assign ctl.valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.ready) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= result_in;
    end
  end

endmodule

// ===== verif/kcl_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcl_checker
// Watches both streams of the keypad code lock controller, predicts the
// result of every accepted key request and compares each returned result
// with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module kcl_checker
  import kcl_pkg::*;
(
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  input  logic                                s_axis_tready,
  input  logic [7:0]                          s_axis_tdata,
  input  logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  input  logic [OUT_DATA_W-1:0]               m_axis_tdata,
  output int                                  mismatches,
  output int                                  pending,
  output mode_t                               lock_mode,
  output logic [CODE_LENGTH-1:0][DIGIT_W-1:0] lock_code
);

  logic [CUR_W-1:0]                    cur_pos;
  logic [FILL_W-1:0]                   fill_cnt;
  logic [CODE_LENGTH-1:0][DIGIT_W-1:0] typed_digits;
  logic [CODE_LENGTH-1:0][DIGIT_W-1:0] first_digits;
  logic                                door_q;

  result_t awaited_results [$];

  task automatic report_mismatch(input string field, input int unsigned got,
                                 input int unsigned want);
    if (mismatches < 100)
      $display("%0t: %s is %0d, predicted %0d", $time, field, got, want);
    mismatches++;
  endtask

  // Apply one key to the lock state and build the result it produces.
  task automatic press_key(input logic [7:0] key, output result_t res);
    res.display_action = ACT_NONE;
    res.display_digit  = '0;
    res.message        = MSG_NONE;
    res.alarm_pulse    = 1'b0;
    if (lock_mode == MODE_MENU) begin
      if (key == KEY_1) begin
        door_q = 1'b1;
      end else if (key == KEY_2) begin
        door_q = 1'b0;
      end else if (key == KEY_3) begin
        lock_mode          = MODE_NEW;
        cur_pos            = '0;
        fill_cnt           = '0;
        res.display_action = ACT_MSG;
        res.message        = MSG_NEW;
      end
    end else if (key == KEY_PLUS && cur_pos == CODE_LENGTH) begin
      res.display_action = ACT_MSG;
      if (fill_cnt < CODE_LENGTH) begin
        res.message = MSG_SHORT;
      end else if (lock_mode == MODE_LOGIN) begin
        if (typed_digits == lock_code) begin
          res.message = MSG_CORRECT;
          lock_mode   = MODE_MENU;
        end else begin
          res.message     = MSG_INCORRECT;
          res.alarm_pulse = 1'b1;
        end
      end else if (lock_mode == MODE_NEW) begin
        first_digits = typed_digits;
        res.message  = MSG_REENTER;
        lock_mode    = MODE_REENTER;
      end else if (first_digits == typed_digits) begin
        lock_code   = first_digits;
        res.message = MSG_CHANGED;
        lock_mode   = MODE_LOGIN;
      end else begin
        res.message     = MSG_MISMATCH;
        res.alarm_pulse = 1'b1;
        lock_mode       = MODE_MENU;
      end
      cur_pos  = '0;
      fill_cnt = '0;
    end else if (key == KEY_DOT && cur_pos > 0) begin
      cur_pos            = cur_pos - 1'b1;
      res.display_action = ACT_LEFT;
    end else if (key == KEY_EQ && cur_pos < CODE_LENGTH) begin
      cur_pos            = cur_pos + 1'b1;
      res.display_action = ACT_RIGHT;
    end else if (key == KEY_SLASH && cur_pos > 0 && cur_pos <= CODE_LENGTH) begin
      // The fill count wraps below zero, so later a short entry may pass.
      cur_pos            = cur_pos - 1'b1;
      fill_cnt           = fill_cnt - 1'b1;
      res.display_action = ACT_ERASE;
    end else if (key >= KEY_0 && key <= KEY_9 && cur_pos < CODE_LENGTH) begin
      res.display_digit     = DIGIT_W'(key - KEY_0);
      typed_digits[cur_pos] = res.display_digit;
      cur_pos               = cur_pos + 1'b1;
      fill_cnt              = fill_cnt + 1'b1;
      res.display_action    = ACT_DIGIT;
    end
    res.door_open = door_q;
    res.mode_now  = lock_mode;
  endtask

  // Sample mid-cycle: a handshake seen here completes at the next rising edge.
  always @(negedge clk) begin : watch
    result_t want;
    result_t got;
    int      value;
    int      i;
    if (rst) begin
      lock_mode    = MODE_LOGIN;
      cur_pos      = '0;
      fill_cnt     = '0;
      typed_digits = '0;
      first_digits = '0;
      door_q       = 1'b0;
      value        = 1234;
      for (i = CODE_LENGTH - 1; i >= 0; i--) begin
        lock_code[i] = DIGIT_W'(value % 10);
        value        = value / 10;
      end
      awaited_results.delete();
      mismatches = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_t'(m_axis_tdata[RESULT_W-1:0]);
        if (awaited_results.size() == 0) begin
          report_mismatch("result with no request pending, tdata", m_axis_tdata, 0);
        end else begin
          want = awaited_results.pop_front();
          if (got.display_action !== want.display_action)
            report_mismatch("display_action", got.display_action, want.display_action);
          if (got.display_digit !== want.display_digit)
            report_mismatch("display_digit", got.display_digit, want.display_digit);
          if (got.message !== want.message)
            report_mismatch("message", got.message, want.message);
          if (got.door_open !== want.door_open)
            report_mismatch("door_open", got.door_open, want.door_open);
          if (got.alarm_pulse !== want.alarm_pulse)
            report_mismatch("alarm_pulse", got.alarm_pulse, want.alarm_pulse);
          if (got.mode_now !== want.mode_now)
            report_mismatch("mode_now", got.mode_now, want.mode_now);
          if ((m_axis_tdata >> RESULT_W) !== '0)
            report_mismatch("tdata padding", m_axis_tdata >> RESULT_W, 0);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        press_key(s_axis_tdata, want);
        awaited_results.push_back(want);
      end
    end
    pending = awaited_results.size();
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives key requests into the keypad code lock controller: a short directed
// opening through the cursor, erase, short-entry and wrapped-fill cases, then
// mostly well-formed login, menu and code-change sessions with some noise.
// Sender bursts and receiver stalls are random. The checker beside the unit
// predicts and compares; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
  import kcl_pkg::*;

  localparam int TOTAL_KEYS = 1650;

  logic                  clk           = 1'b0;
  logic                  rst           = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata  = '0;   // [7:0] key_code
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // [2:0] display_action, [6:3] display_digit, [10:7] message,
  // [11] door_open, [12] alarm_pulse, [14:13] mode_now, [15] zero
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  int    mismatches;
  int    pending;
  mode_t lock_mode;
  logic [CODE_LENGTH-1:0][DIGIT_W-1:0] lock_code;

  int keys_sent   = 0;
  int burst_left  = 0;
  int stall_style = 0;
  int stall_left  = 0;
  int cycle_count = 0;

  always #5 clk = ~clk;

  keypad_code_lock_controller_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Predict and compare beside the unit; mode and code come back as hints
  // so that sessions can be shaped to the current lock state.
  kcl_checker lock_watch (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .mismatches    (mismatches),
    .pending       (pending),
    .lock_mode     (lock_mode),
    .lock_code     (lock_code)
  );

  // Receiver: switch between stall styles at random intervals. Always
  // ready gives stretches with no stalls; the others back the unit up.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_style = $urandom_range(0, 3);
      stall_left  = $urandom_range(20, 300);
    end
    stall_left--;
    cycle_count++;
    case (stall_style)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= 1'($urandom_range(0, 1));
      2:       m_axis_tready <= (cycle_count % 4 != 0);
      default: m_axis_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Present one key request and hold it until accepted. At the end of a
  // burst drop tvalid for a random gap; inside a burst keep it high.
  task automatic send_key(input logic [7:0] key);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= key;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    keys_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(0, 12);
      gap = $urandom_range(1, 6);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Type a full code from the current cursor position, first digit first.
  task automatic type_digits(input logic [CODE_LENGTH-1:0][DIGIT_W-1:0] code);
    int i;
    for (i = 0; i < CODE_LENGTH; i++) send_key(KEY_0 + 8'(code[i]));
  endtask

  // Walk the cursor back to position 0; surplus left moves are ignored.
  task automatic home_cursor();
    int i;
    for (i = 0; i < CODE_LENGTH; i++) send_key(KEY_DOT);
  endtask

  function automatic logic [CODE_LENGTH-1:0][DIGIT_W-1:0] random_code();
    logic [CODE_LENGTH-1:0][DIGIT_W-1:0] code;
    int i;
    for (i = 0; i < CODE_LENGTH; i++) code[i] = DIGIT_W'($urandom_range(0, 9));
    return code;
  endfunction

  initial begin : stimulus
    logic [CODE_LENGTH-1:0][DIGIT_W-1:0] fresh_code;
    int pick;
    int variant;
    int n;
    int i;
    int drain;
    fresh_code = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed opening. Fill every entry position first, so that no later
    // submit compares a digit that was never written.
    type_digits(lock_code);
    send_key(KEY_0 + 8'd5);    // digit at full length: ignored
    send_key(KEY_EQ);          // right at full length: ignored
    send_key(KEY_DOT);
    send_key(KEY_SLASH);
    send_key(KEY_PLUS);        // submit before full length: ignored
    send_key(KEY_EQ);
    send_key(KEY_EQ);
    send_key(KEY_PLUS);        // too few digits: restart entry
    send_key(KEY_DOT);         // left at position 0: ignored
    // Erase below an empty fill count wraps it, so the next submit passes
    // the length check and compares the old digits.
    send_key(KEY_EQ);
    send_key(KEY_SLASH);
    for (i = 0; i < CODE_LENGTH; i++) send_key(KEY_EQ);
    send_key(KEY_PLUS);
    // Menu: unused keys at both extremes, door open and close, code change.
    send_key(8'h00);
    send_key(8'hFF);
    send_key(KEY_1);
    send_key(KEY_2);
    send_key(KEY_1);
    send_key(KEY_3);

    // Random sessions shaped by the current mode, with some noise between.
    while (keys_sent < TOTAL_KEYS) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        n = $urandom_range(1, 4);
        for (i = 0; i < n; i++) begin
          if ($urandom_range(0, 1)) begin
            send_key(8'($urandom_range(0, 255)));
          end else begin
            case ($urandom_range(0, 4))
              0:       send_key(KEY_PLUS);
              1:       send_key(KEY_DOT);
              2:       send_key(KEY_EQ);
              3:       send_key(KEY_SLASH);
              default: send_key(KEY_0 + 8'($urandom_range(0, 9)));
            endcase
          end
        end
      end else begin
        case (lock_mode)
          MODE_LOGIN: begin
            if ($urandom_range(0, 3) != 0) home_cursor();
            variant = $urandom_range(0, 9);
            if (variant < 6) begin
              type_digits(lock_code);
            end else if (variant < 8) begin
              type_digits(random_code());
            end else if (variant == 8) begin
              // Partial entry, then skip to the end: too short.
              n = $urandom_range(0, CODE_LENGTH - 1);
              for (i = 0; i < n; i++) send_key(KEY_0 + 8'($urandom_range(0, 9)));
              for (i = n; i < CODE_LENGTH; i++) send_key(KEY_EQ);
            end else begin
              // Wrap the fill count, then submit without typing.
              send_key(KEY_EQ);
              send_key(KEY_SLASH);
              for (i = 0; i < CODE_LENGTH; i++) send_key(KEY_EQ);
            end
            if ($urandom_range(0, 3) == 0) begin
              // Step back and overwrite the last digit.
              send_key($urandom_range(0, 1) ? KEY_DOT : KEY_SLASH);
              send_key(KEY_0 + 8'($urandom_range(0, 9)));
            end
            send_key(KEY_PLUS);
          end
          MODE_MENU: begin
            variant = $urandom_range(0, 9);
            if (variant < 4) begin
              n = $urandom_range(1, 3);
              for (i = 0; i < n; i++) send_key($urandom_range(0, 1) ? KEY_1 : KEY_2);
            end else if (variant < 8) begin
              send_key(KEY_3);
            end else begin
              send_key($urandom_range(0, 1) ? KEY_0 : KEY_PLUS);
            end
          end
          MODE_NEW: begin
            fresh_code = random_code();
            if ($urandom_range(0, 9) == 0) begin
              send_key(KEY_0 + 8'(fresh_code[0]));
              for (i = 1; i < CODE_LENGTH; i++) send_key(KEY_EQ);
            end else begin
              type_digits(fresh_code);
            end
            send_key(KEY_PLUS);
          end
          default: begin
            // Re-entry: mostly repeat the new code, sometimes miss it.
            if ($urandom_range(0, 3) == 0) home_cursor();
            if ($urandom_range(0, 4) != 0) type_digits(fresh_code);
            else type_digits(random_code());
            send_key(KEY_PLUS);
          end
        endcase
      end
    end

    // Drain: drop tvalid right after the last acceptance and wait for every
    // predicted result.
    s_axis_tvalid <= 1'b0;
    drain = 0;
    while (pending != 0 && drain < 5000) begin
      @(posedge clk);
      drain++;
    end
    repeat (10) @(posedge clk);
    if (pending != 0) $display("%0d predicted results never arrived", pending);
    if (mismatches == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Hard stop, far beyond the slowest correct run.
  initial begin : watchdog
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
